/* hdl/sensor_frame_deframer_assert.svh */
// Assertion macros shared by the sensor frame deframer modules.
`ifndef SENSOR_FRAME_DEFRAMER_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sfd_pkg.sv */
// Types and constants of the sensor frame deframer.
package sfd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ID   = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_LRC  = 3'd5,
    PH_TERM = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  localparam logic [1:0] CFG_NODE_ID = 2'd0;
  localparam logic [1:0] CFG_COMMAND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [7:0]  START_BYTE  = 8'h3A;
  localparam logic [15:0] TERM_WORD   = 16'h0A0D;
  localparam logic [15:0] RST_NODE_ID = 16'h0001;
  localparam logic [15:0] RST_COMMAND = 16'h0009;
  localparam logic [15:0] RST_MAX_LEN = 16'd72;

  typedef struct packed {
    logic [15:0] node_id;
    logic [15:0] command;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [1:0]  frame_status;
  } result_t;

endpackage

/* hdl/sfd_parser.sv */
// Frame parser state and per-byte decode for the sensor frame deframer.
`include "sensor_frame_deframer_assert.svh"

module sfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  sfd_pkg::cfg_t    cfg_i,
  output sfd_pkg::result_t res_o
);

  sfd_pkg::phase_e phase_q, phase_d;
  logic        half_q, half_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] count_q, count_d;

  logic [15:0] word;
  logic        have_word;
  logic        word_phase;
  logic [15:0] count_inc;

  assign word       = {byte_i, low_q};
  assign word_phase = (phase_q == sfd_pkg::PH_ID)  || (phase_q == sfd_pkg::PH_CMD) ||
                      (phase_q == sfd_pkg::PH_LEN) || (phase_q == sfd_pkg::PH_LRC) ||
                      (phase_q == sfd_pkg::PH_TERM);
  assign have_word  = word_phase && half_q;
  assign count_inc  = count_q + 16'd1;

  // Next state. Every path back to hunting clears the whole frame context.
  always_comb begin
    phase_d = phase_q;
    half_d  = half_q;
    low_d   = low_q;
    len_d   = len_q;
    sum_d   = sum_q;
    count_d = count_q;

    if (word_phase) begin
      if (!half_q) begin
        low_d  = byte_i;
        half_d = 1'b1;
      end else begin
        low_d  = 8'd0;
        half_d = 1'b0;
      end
    end

    case (phase_q)
      sfd_pkg::PH_ID: begin
        if (have_word) begin
          if (word != cfg_i.node_id) begin
            phase_d = sfd_pkg::PH_HUNT;
          end else begin
            sum_d   = sum_q + word;
            phase_d = sfd_pkg::PH_CMD;
          end
        end
      end
      sfd_pkg::PH_CMD: begin
        if (have_word) begin
          if (word != cfg_i.command) begin
            phase_d = sfd_pkg::PH_HUNT;
          end else begin
            sum_d   = sum_q + word;
            phase_d = sfd_pkg::PH_LEN;
          end
        end
      end
      sfd_pkg::PH_LEN: begin
        if (have_word) begin
          if (word > cfg_i.max_len) begin
            phase_d = sfd_pkg::PH_HUNT;
          end else begin
            len_d   = word;
            sum_d   = sum_q + word;
            count_d = 16'd0;
            phase_d = (word == 16'd0) ? sfd_pkg::PH_LRC : sfd_pkg::PH_DATA;
          end
        end
      end
      sfd_pkg::PH_DATA: begin
        sum_d   = sum_q + {8'd0, byte_i};
        count_d = count_inc;
        if (count_inc == len_q) begin
          phase_d = sfd_pkg::PH_LRC;
        end
      end
      sfd_pkg::PH_LRC: begin
        if (have_word) begin
          phase_d = ((sum_q != 16'd0) && (sum_q == word)) ? sfd_pkg::PH_TERM
                                                           : sfd_pkg::PH_HUNT;
        end
      end
      sfd_pkg::PH_TERM: begin
        if (have_word) begin
          phase_d = sfd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_d = (byte_i == sfd_pkg::START_BYTE) ? sfd_pkg::PH_ID : sfd_pkg::PH_HUNT;
      end
    endcase

    if (phase_d == sfd_pkg::PH_HUNT) begin
      half_d  = 1'b0;
      low_d   = 8'd0;
      len_d   = 16'd0;
      sum_d   = 16'd0;
      count_d = 16'd0;
    end
  end

  // Result of the current byte.
  always_comb begin
    res_o = '0;
    case (phase_q)
      sfd_pkg::PH_LEN: begin
        if (have_word && (word > cfg_i.max_len)) begin
          res_o.frame_status = sfd_pkg::ST_ERROR;
        end
      end
      sfd_pkg::PH_DATA: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = count_q;
      end
      sfd_pkg::PH_LRC: begin
        if (have_word && !((sum_q != 16'd0) && (sum_q == word))) begin
          res_o.frame_status = sfd_pkg::ST_ERROR;
        end
      end
      sfd_pkg::PH_TERM: begin
        if (have_word && (word == sfd_pkg::TERM_WORD)) begin
          res_o.frame_status = sfd_pkg::ST_DONE;
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_HUNT;
      half_q  <= 1'b0;
      low_q   <= 8'd0;
      len_q   <= 16'd0;
      sum_q   <= 16'd0;
      count_q <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      half_q  <= half_d;
      low_q   <= low_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  `SFD_ASSERT_IMPL(a_data_count_in_range, clk_i, rst_ni, phase_q == sfd_pkg::PH_DATA, (len_q != 16'd0) && (count_q < len_q), "payload count outside frame length")
  `SFD_ASSERT_IMPL(a_half_only_in_words, clk_i, rst_ni, half_q, word_phase, "low byte held outside a word field")
  `SFD_ASSERT_IMPL(a_hunt_is_clear, clk_i, rst_ni, phase_q == sfd_pkg::PH_HUNT, (sum_q == 16'd0) && (count_q == 16'd0) && !half_q, "frame context not cleared while hunting")

endmodule

/* hdl/sensor_frame_deframer.sv */
// Top level of the sensor frame deframer: stream ports, config registers, pipeline.
// The block receives a serial byte stream, one byte per input transaction on
// the s_axis channel, and finds sensor bus frames in it: start byte 0x3A,
// little-endian id, command and length words, the payload, a 16-bit LRC and
// the terminator 0x0D 0x0A. Every input byte yields exactly one output
// transaction on the m_axis channel carrying a status (none, frame done,
// error), and for payload bytes the byte and its index within the payload.
// Id, command and length limit come from three registers written through the
// cfg port; they should only be changed while the stream is quiet.
// The path is an input register, combinational decode against the parser
// state, and an output register, so the result of a byte passes the input
// register and then the output register before it is presented on m_axis.
// One byte is taken every cycle while m_axis_tready stays high; the
// throughput is set by the update of the running sum and word compares in
// the parser.
// When the receiver holds m_axis_tready low the result stays in the output
// register, the next byte waits in the input register, and s_axis_tready
// drops only once both are full; nothing is lost or repeated.
// Reset is asynchronous and active low: both registers empty, the parser
// hunts for a start byte, and the registers return to id 1, command 9 and
// a maximum length of 72.
`include "sensor_frame_deframer_assert.svh"

module sensor_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] payload_index
  output logic [2:0]  m_axis_tuser,   // [1:0] frame_status, [2] payload_valid
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  sfd_pkg::cfg_t    cfg_q;
  sfd_pkg::result_t res;
  sfd_pkg::result_t out_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;

  // A byte in the input register moves on whenever the output register is
  // empty or being emptied in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id <= sfd_pkg::RST_NODE_ID;
      cfg_q.command <= sfd_pkg::RST_COMMAND;
      cfg_q.max_len <= sfd_pkg::RST_MAX_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::CFG_NODE_ID: cfg_q.node_id <= cfg_data_i;
        sfd_pkg::CFG_COMMAND: cfg_q.command <= cfg_data_i;
        sfd_pkg::CFG_MAX_LEN: cfg_q.max_len <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.payload_index, out_q.payload_byte};
  assign m_axis_tuser  = {out_q.payload_valid, out_q.frame_status};

  // Both registers full and the receiver stalled: no new byte may enter.
  `SFD_ASSERT_IMPL(a_full_blocks_input, clk_i, rst_ni, in_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready, "input taken while pipeline is full and stalled")
  // An accepted byte always lands in the input register.
  `SFD_ASSERT_NEXT(a_accept_fills_input, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, in_valid_q, "accepted byte not held")
  // A payload byte never carries a frame status, and non-payload results carry a zero payload byte and index.
  `SFD_ASSERT_IMPL(a_payload_no_status, clk_i, rst_ni, out_valid_q && !out_q.payload_valid, (out_q.payload_index == 16'd0) && (out_q.payload_byte == 8'd0), "stray payload fields on non-payload result")
  `SFD_ASSERT_IMPL(a_status_code_legal, clk_i, rst_ni, out_valid_q, (out_q.frame_status == sfd_pkg::ST_NONE) || !out_q.payload_valid, "status reported on a payload byte")

endmodule
